// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted (active low)
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: rtl/bdq_pkg.sv
// -----------------------------------------------------------------------------
// bdq_pkg
// Shared types, codes and elaboration helpers of the bounded deque.
// -----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int TREE_RADIX_LOG2 = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4,
    KIND_INSERT     = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP_FRONT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] element;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } result_t;

  // number of nodes on level l of a radix-8 reduction over n leaves (level 0 = leaves)
  function automatic int level_size(input int n, input int l);
    int s;
    s = n;
    for (int k = 0; k < 16; k++) begin
      if (k < l) begin
        s = (s + 7) >> TREE_RADIX_LOG2;
      end
    end
    return s;
  endfunction

  // registered levels needed to reduce n leaves to a single node
  function automatic int tree_levels(input int n);
    int s;
    int l;
    s = n;
    l = 0;
    for (int k = 0; k < 16; k++) begin
      if (s > 1) begin
        s = (s + 7) >> TREE_RADIX_LOG2;
        l++;
      end
    end
    return l;
  endfunction

  // offset of level l in the flat node store, which holds levels 1 and up
  function automatic int level_base(input int n, input int l);
    int b;
    b = 0;
    for (int k = 1; k < 16; k++) begin
      if (k < l) begin
        b += level_size(n, k);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bdq_if.sv
// -----------------------------------------------------------------------------
// bdq_if
// Request and response channels of the bounded deque (valid/ready).
// -----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::KIND_W-1:0]   kind;
  logic [bdq_pkg::VALUE_W-1:0]  value;
  logic [bdq_pkg::POS_W-1:0]    position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface bdq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bdq_pkg::VALUE_W-1:0]   element;
  logic [bdq_pkg::STATUS_W-1:0]  status;
  logic [bdq_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output element, output status, output count, input ready);
  modport sink   (input valid, input element, input status, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/bdq_cell.sv
// -----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row; shifts with its neighbours.
// -----------------------------------------------------------------------------
`default_nettype none

module bdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX_W    = 6,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  bdq_pkg::cell_op_e          op_i,
  input  wire logic [INDEX_W-1:0]    pos_i,
  input  wire logic [INDEX_W-1:0]    sel_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic [DATA_WIDTH-1:0] prev_i,
  input  wire logic [DATA_WIDTH-1:0] next_i,
  output logic      [DATA_WIDTH-1:0] data_o,
  output logic      [DATA_WIDTH-1:0] tap_o
);
  import bdq_pkg::*;

  localparam logic [INDEX_W-1:0] MyIdx = INDEX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        // open a gap at pos: cells behind it take the left neighbour
        if (MyIdx > pos_i) begin
          data_d = prev_i;
        end else if (MyIdx == pos_i) begin
          data_d = word_i;
        end
      end
      CELL_POP_FRONT: data_d = next_i;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // drive the select tree only when this cell is addressed
  assign tap_o  = (sel_i == MyIdx) ? data_q : '0;

endmodule

`default_nettype wire

// File: rtl/bdq_sel_tree.sv
// -----------------------------------------------------------------------------
// bdq_sel_tree
// Registered radix-8 OR tree that brings the addressed cell to one word.
// -----------------------------------------------------------------------------
`default_nettype none

module bdq_sel_tree #(
  parameter int LEAVES = 64,
  parameter int WIDTH  = 32
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic      [WIDTH-1:0] root_o
);
  import bdq_pkg::*;

  localparam int Levels    = tree_levels(LEAVES);
  localparam int NodeCount = level_base(LEAVES, Levels + 1);

  logic [WIDTH-1:0] node_q [NodeCount];

  for (genvar lv = 1; lv <= Levels; lv++) begin : g_lvl
    localparam int Size    = level_size(LEAVES, lv);
    localparam int SrcSize = level_size(LEAVES, lv - 1);
    localparam int Base    = level_base(LEAVES, lv);
    localparam int SrcBase = level_base(LEAVES, lv - 1);

    for (genvar g = 0; g < Size; g++) begin : g_node
      logic [WIDTH-1:0] node_d;

      if (lv == 1) begin : g_from_leaf
        always_comb begin
          node_d = '0;
          for (int c = 0; c < 8; c++) begin
            if (g * 8 + c < SrcSize) begin
              node_d = node_d | leaf_i[(g * 8 + c < SrcSize) ? g * 8 + c : 0];
            end
          end
        end
      end else begin : g_from_node
        always_comb begin
          node_d = '0;
          for (int c = 0; c < 8; c++) begin
            if (g * 8 + c < SrcSize) begin
              node_d = node_d | node_q[SrcBase + ((g * 8 + c < SrcSize) ? g * 8 + c : 0)];
            end
          end
        end
      end

      always_ff @(posedge clk_i) begin
        node_q[Base + g] <= node_d;
      end
    end
  end

  assign root_o = node_q[level_base(LEAVES, Levels)];

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_indexed_insert.sv
// -----------------------------------------------------------------------------
// bounded_deque_with_indexed_insert
// Bounded double-ended queue held in a row of shifting cells, with indexed
// read and indexed insert.
// -----------------------------------------------------------------------------
//
//   channel | dir | payload                        | handshake
//   --------+-----+--------------------------------+------------------------
//   req_i   | in  | kind, value, position          | valid/ready, sink
//   rsp_o   | out | element, status, count         | valid/ready, source
//
// Push front/back, pop front, insert, unused kinds and every error case
// finish at the accepting edge: the row of cells shifts there and the
// response is registered there. Read and pop back pass the select tree:
// the tree address is registered at the accepting edge, the addressed
// word passes the registered levels of the tree, and the response is
// registered after the walk, after which req_i reopens.
// Reset clears the count and the control state only; cell contents need
// no clearing pass. A response waiting on a stalled rsp_o does not block
// the next request: a second response slot takes it, and req_i stalls
// once both are full and while a read or pop back walks the tree.
//
`default_nettype none

`include "assert_macros.svh"

module bounded_deque_with_indexed_insert #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  localparam int IdxW   = $clog2(CAPACITY);
  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int CmpW   = (CntW > POS_W) ? CntW : POS_W;
  localparam int Levels = tree_levels(CAPACITY);
  localparam int WalkW  = $clog2(Levels + 1);

  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [WalkW-1:0]  walk_cnt_q, walk_cnt_d;
  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   sel_q;

  logic              out_v_q, spare_v_q;
  result_t           out_q, spare_q;

  logic              req_acc, rsp_acc, walk_done, res_wr;
  result_t           res_d;

  // ---------------------------------------------------------------------------
  // Request decode: status, cell operation and new count from the held count
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0]       pos_ext, cnt_ext;
  logic                  is_full, is_empty;
  status_e               dec_status;
  cell_op_e              dec_op;
  logic                  dec_walk;
  logic [IdxW-1:0]       dec_idx;
  logic [VALUE_W-1:0]    dec_elem;
  logic [CntW-1:0]       dec_count;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [DATA_WIDTH-1:0] tree_root;
  logic [DATA_WIDTH-1:0] word;

  assign pos_ext  = CmpW'(req_i.position);
  assign cnt_ext  = CmpW'(count_q);
  assign is_full  = (count_q == CntFull);
  assign is_empty = (count_q == '0);
  assign word     = DATA_WIDTH'(req_i.value);

  always_comb begin
    dec_status = STATUS_OK;
    dec_op     = CELL_HOLD;
    dec_walk   = 1'b0;
    dec_idx    = '0;
    dec_elem   = '0;
    dec_count  = count_q;
    unique case (req_i.kind)
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          dec_status = STATUS_FULL;
        end else begin
          dec_op    = CELL_INSERT;
          dec_count = count_q + CntOne;
        end
      end
      KIND_PUSH_BACK: begin
        if (is_full) begin
          dec_status = STATUS_FULL;
        end else begin
          dec_op    = CELL_INSERT;
          dec_idx   = IdxW'(count_q);
          dec_count = count_q + CntOne;
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          dec_status = STATUS_EMPTY;
        end else begin
          // front cell is fixed, so its word is there without the tree
          dec_op    = CELL_POP_FRONT;
          dec_elem  = VALUE_W'(cell_data[0]);
          dec_count = count_q - CntOne;
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          dec_status = STATUS_EMPTY;
        end else begin
          // drop the back by shrinking the count; fetch its word via the tree
          dec_walk  = 1'b1;
          dec_idx   = IdxW'(count_q - CntOne);
          dec_count = count_q - CntOne;
        end
      end
      KIND_READ: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_walk = 1'b1;
          dec_idx  = IdxW'(req_i.position);
        end
      end
      KIND_INSERT: begin
        if (is_full) begin
          dec_status = STATUS_FULL;
        end else if (pos_ext > cnt_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_op    = CELL_INSERT;
          dec_idx   = IdxW'(req_i.position);
          dec_count = count_q + CntOne;
        end
      end
      default: begin
        // unused kinds: empty response, nothing changes
        dec_status = STATUS_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Row of cells and select tree
  // ---------------------------------------------------------------------------
  cell_op_e cell_op;

  assign cell_op = req_acc ? dec_op : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int Prev = (i == 0) ? 0 : i - 1;
    localparam int Next = (i == CAPACITY - 1) ? i : i + 1;

    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX_W    (IdxW),
      .INDEX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .pos_i  (dec_idx),
      .sel_i  (sel_q),
      .word_i (word),
      .prev_i (cell_data[Prev]),
      .next_i (cell_data[Next]),
      .data_o (cell_data[i]),
      .tap_o  (cell_tap[i])
    );
  end

  bdq_sel_tree #(
    .LEAVES (CAPACITY),
    .WIDTH  (DATA_WIDTH)
  ) u_sel_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_tap),
    .root_o (tree_root)
  );

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  assign req_acc = req_i.valid && req_i.ready;
  assign rsp_acc = rsp_o.valid && rsp_o.ready;

  always_comb begin
    state_d    = state_q;
    walk_cnt_d = walk_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc && dec_walk) begin
          state_d    = ST_WALK;
          walk_cnt_d = WalkW'(Levels);
        end
      end
      ST_WALK: begin
        if (walk_cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          walk_cnt_d = walk_cnt_q - WalkW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    walk_done   = 1'b0;
    unique case (state_q)
      ST_IDLE: req_i.ready = !spare_v_q;
      ST_WALK: walk_done   = (walk_cnt_q == '0);
      default: req_i.ready = 1'b0;
    endcase
  end

  // new response: immediate from the decode, or the tree word after a walk
  assign res_wr = (req_acc && !dec_walk) || walk_done;

  always_comb begin
    if (walk_done) begin
      res_d.element = VALUE_W'(tree_root);
      res_d.status  = STATUS_OK;
      res_d.count   = COUNT_W'(count_q);
    end else begin
      res_d.element = dec_elem;
      res_d.status  = dec_status;
      res_d.count   = COUNT_W'(dec_count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      walk_cnt_q <= '0;
      count_q    <= '0;
    end else begin
      state_q    <= state_d;
      walk_cnt_q <= walk_cnt_d;
      if (req_acc) begin
        count_q <= dec_count;
      end
    end
  end

  // hold the tree address for the whole walk
  always_ff @(posedge clk_i) begin
    if (req_acc && dec_walk) begin
      sel_q <= dec_idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Response slots: out_q faces the port, spare_q catches a response that
  // arrives while out_q is stalled
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      if (!out_v_q) begin
        out_v_q <= res_wr;
      end else if (rsp_acc) begin
        out_v_q   <= spare_v_q || res_wr;
        spare_v_q <= 1'b0;
      end else if (res_wr) begin
        spare_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q) begin
      out_q <= res_d;
    end else if (rsp_acc) begin
      out_q <= spare_v_q ? spare_q : res_d;
    end else if (res_wr) begin
      spare_q <= res_d;
    end
  end

  assign rsp_o.valid   = out_v_q;
  assign rsp_o.element = out_q.element;
  assign rsp_o.status  = out_q.status;
  assign rsp_o.count   = out_q.count;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_CLK(a_walk_no_spare, clk_i, rst_ni, (state_q == ST_WALK) |-> !spare_v_q, "spare slot busy during walk")
  `ASSERT_CLK(a_wr_slot_free, clk_i, rst_ni, res_wr |-> !spare_v_q, "response written with both slots full")
  `ASSERT_CLK(a_walk_ends_valid, clk_i, rst_ni, walk_done |=> out_v_q, "walk ended without a response")
  `ASSERT_CLK(a_count_idle, clk_i, rst_ni, !req_acc |=> $stable(count_q), "count moved without a request")
  `ASSERT_CLK(a_count_step, clk_i, rst_ni, req_acc |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CntOne) || (count_q + CntOne == $past(count_q)), "count moved by more than one")

endmodule

`default_nettype wire

// File: test/bounded_deque_with_indexed_insert_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bounded_deque_with_indexed_insert_tb
// Self-checking bench for the bounded deque. A clocked driver feeds requests
// from a planned list, a clocked monitor takes responses under random
// back-pressure, and a shadow deque predicts element, status and count for
// every request in order of acceptance.
// -----------------------------------------------------------------------------

module bounded_deque_with_indexed_insert_tb;
  import bdq_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // kinds that the block must accept and ignore
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // request mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  localparam int RANDOM_REQUESTS = 1725;
  localparam int DRAIN_POINT_A   = 21;
  localparam int DRAIN_POINT_B   = 900;
  localparam int CALM_FROM       = 700;
  localparam int CALM_TO         = 1000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int REPORT_LIMIT    = 60;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    bit                 wait_for_drain;
  } deque_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_indexed_insert #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow deque: the contents the block should hold, front at index 0
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] shadow_cells [CAPACITY];
  int                 shadow_held;

  deque_req_t planned_requests [$];
  result_t    awaited_responses [$];
  int         planned_held;     // occupancy as seen while planning, to aim positions
  int         planned_total;

  bit req_taken;                // set at the accepting edge, cleared by the driver
  int accepted_requests;
  int taken_responses;
  int mismatches;
  int cycles;
  int status_seen [4];
  int spare_kinds_seen;
  int peak_held;

  // Open a slot at the given position, moving later words back by one.
  function automatic void shadow_place(int at, logic [VALUE_W-1:0] word);
    for (int i = shadow_held; i > at; i--) begin
      shadow_cells[i] = shadow_cells[i-1];
    end
    shadow_cells[at] = word;
    shadow_held++;
  endfunction

  // Remove the word at the given position, closing the gap behind it.
  function automatic logic [VALUE_W-1:0] shadow_take(int at);
    logic [VALUE_W-1:0] word;
    word = shadow_cells[at];
    for (int i = at; i + 1 < shadow_held; i++) begin
      shadow_cells[i] = shadow_cells[i+1];
    end
    shadow_held--;
    return word;
  endfunction

  // Apply one request to the shadow deque and return the response it must give.
  function automatic result_t predict_response(logic [KIND_W-1:0] kind,
                                               logic [VALUE_W-1:0] word,
                                               logic [POS_W-1:0] pos);
    result_t rsp;
    rsp.element = '0;
    rsp.status  = STATUS_OK;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_held >= CAPACITY) begin
          rsp.status = STATUS_FULL;
        end else begin
          shadow_place((kind == KIND_PUSH_FRONT) ? 0 : shadow_held, word);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (shadow_held == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          rsp.element = shadow_take((kind == KIND_POP_FRONT) ? 0 : shadow_held - 1);
        end
      end
      KIND_READ: begin
        if (int'(pos) >= shadow_held) begin
          rsp.status = STATUS_RANGE;
        end else begin
          rsp.element = shadow_cells[pos];
        end
      end
      KIND_INSERT: begin
        // a full deque reports full even when the position is also out of range
        if (shadow_held >= CAPACITY) begin
          rsp.status = STATUS_FULL;
        end else if (int'(pos) > shadow_held) begin
          rsp.status = STATUS_RANGE;
        end else begin
          shadow_place(int'(pos), word);
        end
      end
      default: begin
        // spare kinds leave everything as it is
      end
    endcase
    rsp.count = COUNT_W'(shadow_held);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Planning of the request list
  // ---------------------------------------------------------------------------

  // Append a request; track occupancy so that later positions can be aimed.
  task automatic plan_request(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] word,
                              logic [POS_W-1:0] pos);
    deque_req_t r;
    r.kind           = kind;
    r.value          = word;
    r.position       = pos;
    r.wait_for_drain = (planned_total == DRAIN_POINT_A) || (planned_total == DRAIN_POINT_B);
    planned_requests = {planned_requests, r};
    planned_total++;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (planned_held < CAPACITY) planned_held++;
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (planned_held > 0) planned_held--;
      end
      KIND_INSERT: begin
        if (planned_held < CAPACITY && int'(pos) <= planned_held) planned_held++;
      end
      default: begin
      end
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return $urandom;
  endfunction

  // Mostly a legal position with the last legal one favoured; now and then past the end.
  function automatic logic [POS_W-1:0] pick_position(bit for_insert);
    int last_ok;
    int roll;
    last_ok = planned_held - (for_insert ? 0 : 1);
    roll    = $urandom_range(0, 99);
    if (last_ok >= 0 && roll < 12) return POS_W'(last_ok);
    if (last_ok >= 0 && roll < 85) return POS_W'($urandom_range(0, last_ok));
    return POS_W'($urandom_range(last_ok + 1, (1 << POS_W) - 1));
  endfunction

  task automatic plan_burst(int mix, int n);
    int push_to, insert_to, pop_to, read_to, spare_to;
    int roll;
    case (mix)
      MIX_FILL:  begin push_to = 45; insert_to = 70; pop_to = 82; read_to = 94; end
      MIX_DRAIN: begin push_to = 12; insert_to = 20; pop_to = 75; read_to = 92; end
      default:   begin push_to = 25; insert_to = 40; pop_to = 70; read_to = 92; end
    endcase
    spare_to = read_to + 2;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_to) begin
        plan_request($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                     pick_word(), POS_W'($urandom));
      end else if (roll < insert_to) begin
        plan_request(KIND_INSERT, pick_word(), pick_position(1'b1));
      end else if (roll < pop_to) begin
        plan_request($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK,
                     $urandom, POS_W'($urandom));
      end else if (roll < read_to) begin
        plan_request(KIND_READ, $urandom, pick_position(1'b0));
      end else if (roll < spare_to) begin
        plan_request($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI,
                     $urandom, POS_W'($urandom));
      end else begin
        // noise: any kind, any position
        plan_request(KIND_W'($urandom_range(0, 7)), $urandom, POS_W'($urandom));
      end
    end
  endtask

  // Hold both sides steady through a middle stretch of the run.
  function automatic bit take_a_break();
    if (accepted_requests >= CALM_FROM && accepted_requests < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes the request channel at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    deque_req_t nxt;
    if (rst_ni) begin
      if (req_if.valid && !req_taken) begin
        // hold the request until the block takes it
      end else if (planned_requests.size() != 0 &&
                   !(planned_requests[0].wait_for_drain && awaited_responses.size() != 0) &&
                   !take_a_break()) begin
        nxt = planned_requests[0];
        planned_requests.delete(0);
        req_if.valid    <= 1'b1;
        req_if.kind     <= nxt.kind;
        req_if.value    <= nxt.value;
        req_if.position <= nxt.position;
      end else begin
        req_if.valid <= 1'b0;
      end
      rsp_if.ready <= !take_a_break();
      req_taken = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the response first, then predicts for the request taken
  // at the same edge
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch on response %0d: expected 0x%0h, got 0x%0h",
               $time, field, taken_responses, want, got);
    end else if (mismatches == REPORT_LIMIT + 1) begin
      $display("%0t: further mismatches counted but not shown", $time);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing outstanding: element 0x%0h status %0d count %0d",
                   $time, rsp_if.element, rsp_if.status, rsp_if.count);
        end else begin
          want = awaited_responses[0];
          awaited_responses.delete(0);
          if (rsp_if.element !== want.element) report_field("element", want.element, rsp_if.element);
          if (rsp_if.status !== want.status) report_field("status", want.status, rsp_if.status);
          if (rsp_if.count !== want.count) report_field("count", want.count, rsp_if.count);
        end
        taken_responses++;
      end
      if (req_if.valid && req_if.ready) begin
        want = predict_response(req_if.kind, req_if.value, req_if.position);
        awaited_responses = {awaited_responses, want};
        status_seen[want.status]++;
        if (req_if.kind == KIND_SPARE_LO || req_if.kind == KIND_SPARE_HI) spare_kinds_seen++;
        if (shadow_held > peak_held) peak_held = shadow_held;
        accepted_requests++;
        req_taken = 1'b1;
      end
    end
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d responses outstanding",
               $time, CYCLE_LIMIT, awaited_responses.size());
      $display("bounded_deque_with_indexed_insert verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int mix;
    int len;
    int random_planned;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    shadow_held     = 0;
    planned_held    = 0;
    planned_total   = 0;
    req_taken       = 1'b0;
    accepted_requests = 0;
    taken_responses   = 0;
    mismatches        = 0;
    cycles            = 0;
    spare_kinds_seen  = 0;
    peak_held         = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // directed: errors on an empty deque, spare kinds, every operation, edges of range
    plan_request(KIND_POP_FRONT,  32'h0,         7'd0);   // empty
    plan_request(KIND_POP_BACK,   32'hFFFF_FFFF, 7'd127); // empty
    plan_request(KIND_READ,       32'h0,         7'd0);   // nothing to read
    plan_request(KIND_INSERT,     32'h1234_5678, 7'd1);   // past the end
    plan_request(KIND_SPARE_LO,   32'hDEAD_BEEF, 7'd3);
    plan_request(KIND_SPARE_HI,   32'hFFFF_FFFF, 7'd127);
    plan_request(KIND_INSERT,     32'hFFFF_FFFF, 7'd0);   // insert into empty
    plan_request(KIND_PUSH_FRONT, 32'h0,         7'd127);
    plan_request(KIND_PUSH_BACK,  32'hA5A5_5A5A, 7'd0);
    plan_request(KIND_INSERT,     32'h0000_0001, 7'd3);   // position equal to count appends
    plan_request(KIND_INSERT,     32'h8000_0001, 7'd1);   // shifts later words back
    plan_request(KIND_READ,       32'h0,         7'd0);
    plan_request(KIND_READ,       32'h0,         7'd4);   // last element
    plan_request(KIND_READ,       32'h0,         7'd5);   // one past the end
    plan_request(KIND_READ,       32'hFFFF_FFFF, 7'd127);
    plan_request(KIND_INSERT,     32'h5555_AAAA, 7'd7);   // past the end
    plan_request(KIND_READ,       32'h0,         7'd64);
    plan_request(KIND_POP_FRONT,  32'h0,         7'd0);
    plan_request(KIND_POP_BACK,   32'h0,         7'd0);
    plan_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF, 7'd0);
    plan_request(KIND_READ,       32'h0,         7'd2);

    // random: alternate filling, balanced and draining stretches so that
    // the deque runs full and empty many times
    random_planned = 0;
    mix = 0;
    while (random_planned < RANDOM_REQUESTS) begin
      len = $urandom_range(40, 120);
      if (len > RANDOM_REQUESTS - random_planned) len = RANDOM_REQUESTS - random_planned;
      case (mix % 4)
        0:       plan_burst(MIX_FILL, len);
        2:       plan_burst(MIX_DRAIN, len);
        default: plan_burst(MIX_EVEN, len);
      endcase
      random_planned += len;
      mix++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (planned_requests.size() != 0 || req_if.valid) @(posedge clk_i);
    while (awaited_responses.size() != 0) @(posedge clk_i);
    // let any stray response show itself
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d responses: ok %0d, empty %0d, full %0d, range %0d",
             accepted_requests, taken_responses, status_seen[STATUS_OK],
             status_seen[STATUS_EMPTY], status_seen[STATUS_FULL], status_seen[STATUS_RANGE]);
    $display("Peak occupancy %0d of %0d, %0d spare-kind requests, %0d mismatches",
             peak_held, CAPACITY, spare_kinds_seen, mismatches);
    if (mismatches == 0) begin
      $display("bounded_deque_with_indexed_insert verification clean");
    end else begin
      $display("bounded_deque_with_indexed_insert verification failed");
    end
    $finish;
  end

endmodule

// File: bounded_deque_with_indexed_insert.f
+incdir+rtl
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_cell.sv
rtl/bdq_sel_tree.sv
rtl/bounded_deque_with_indexed_insert.sv
test/bounded_deque_with_indexed_insert_tb.sv
